// ----- sv/i2rt_pkg.sv -----
// Shared types, constants and helpers for the integer to radix text converter.
package i2rt_pkg;

   // Width of the signed value that is converted.
   localparam int VALUE_WIDTH = 32;
   // Width of the radix field and of one stored digit.
   localparam int RADIX_W = 6;
   localparam int FLAGS_W = 4;
   localparam int CHAR_W = 7;
   // Quotient bits resolved per divide cycle; VALUE_WIDTH is a multiple of it.
   localparam int DIV_STEPS = 8;
   localparam int DIV_CHUNKS = VALUE_WIDTH / DIV_STEPS;
   localparam int CHUNK_W = (DIV_CHUNKS > 1) ? $clog2(DIV_CHUNKS) : 1;
   // Digit stack depth: base 2 gives at most VALUE_WIDTH digits.
   localparam int DIG_DEPTH = VALUE_WIDTH;
   localparam int DIG_AW = $clog2(DIG_DEPTH);
   localparam int DIG_CW = $clog2(DIG_DEPTH + 1);
   // Prefix and sign: "#<" two digits ">" and one sign character.
   localparam int HEAD_MAX = 6;
   localparam int HEAD_W = $clog2(HEAD_MAX + 1);

   // Format flag bit positions.
   localparam int FLAG_PLUS = 0;
   localparam int FLAG_SPACE = 1;
   localparam int FLAG_PREFIX = 2;
   localparam int FLAG_UPPER = 3;

   // Radix limits and the bases with letter prefixes.
   localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_BIN = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_OCT = 6'd8;
   localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_HEX = 6'd16;

   // Digit indexes of the prefix letters b, o and x.
   localparam logic [RADIX_W-1:0] DIGIT_B = 6'd11;
   localparam logic [RADIX_W-1:0] DIGIT_O = 6'd24;
   localparam logic [RADIX_W-1:0] DIGIT_X = 6'd33;

   // ASCII codes.
   localparam logic [CHAR_W-1:0] CH_NUL = 7'h00;
   localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;
   localparam logic [CHAR_W-1:0] CH_HASH = 7'h23;
   localparam logic [CHAR_W-1:0] CH_PLUS = 7'h2B;
   localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] CH_ZERO = 7'h30;
   localparam logic [CHAR_W-1:0] CH_LT = 7'h3C;
   localparam logic [CHAR_W-1:0] CH_GT = 7'h3E;
   localparam logic [CHAR_W-1:0] CH_UPPER_A = 7'h41;
   localparam logic [CHAR_W-1:0] CH_LOWER_A = 7'h61;

   typedef struct packed {
      logic signed [VALUE_WIDTH-1:0] value;
      logic [RADIX_W-1:0]            radix;
      logic [FLAGS_W-1:0]            format_flags;
   } req_type;

   typedef struct packed {
      logic [CHAR_W-1:0] text_char;
      logic              last;
      logic              bad_radix;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic div_step;
      logic emit;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic bad;
      logic div_done;
      logic emit_last;
      logic out_free;
   } status_type;

   // Map a digit value 0..35 to its ASCII character.
   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d,
                                                    input logic upper);
      logic [CHAR_W-1:0] d_ext;
      d_ext = {1'b0, d};
      if (d < RADIX_DEC) begin
         return CH_ZERO + d_ext;
      end else if (upper) begin
         return CH_UPPER_A + d_ext - {1'b0, RADIX_DEC};
      end else begin
         return CH_LOWER_A + d_ext - {1'b0, RADIX_DEC};
      end
   endfunction

endpackage

// ----- sv/i2rt_ctrl.sv -----
// Sequencing state machine: accept, divide out digits, emit characters.
module i2rt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  i2rt_pkg::status_type status,
   output i2rt_pkg::cmd_type    cmd
);
   import i2rt_pkg::*;

   state_type state_ff;
   state_type state_in;

   // Hold the state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Advance the state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (status.bad || status.div_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.out_free && status.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Drive commands.
   always_comb begin
      req_ready = 1'b0;
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         ST_DIVIDE: begin
            cmd.div_step = !status.bad;
         end
         ST_EMIT: begin
            cmd.emit = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

// ----- sv/i2rt_datapath.sv -----
// Divider, digit stack, prefix builder and output register.
module i2rt_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  i2rt_pkg::req_type    req_data,
   input  i2rt_pkg::cmd_type    cmd,
   output i2rt_pkg::status_type status,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output i2rt_pkg::rsp_type    rsp_data
);
   import i2rt_pkg::*;

   // Conversion registers.
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [RADIX_W-1:0]     rem_ff, rem_in;
   logic [RADIX_W-1:0]     base_ff, base_in;
   logic [FLAGS_W-1:0]     flags_ff, flags_in;
   logic                   neg_ff, neg_in;
   logic [CHUNK_W-1:0]     cnt_ff, cnt_in;
   logic [DIG_CW-1:0]      nd_ff, nd_in;
   logic [HEAD_W-1:0]      hp_ff, hp_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   // Digit stack, least significant digit at the bottom.
   logic [RADIX_W-1:0] dig_mem [DIG_DEPTH];
   // Registered top of the stack.
   logic [RADIX_W-1:0] dig_rd_ff;

   // Combinational helpers.
   logic [VALUE_WIDTH-1:0] mag;
   logic [VALUE_WIDTH-1:0] q_next;
   logic [RADIX_W-1:0]     r_next;
   logic [RADIX_W:0]       r_wide;
   logic                   chunk_last;
   logic                   bad;
   logic                   upper;
   logic [CHAR_W-1:0]      head [HEAD_MAX];
   logic [HEAD_W-1:0]      head_len;
   logic [CHAR_W-1:0]      tens_char;
   logic [CHAR_W-1:0]      ones_char;
   logic [RADIX_W-1:0]     ones_val;
   logic [RADIX_W-1:0]     tens_val;
   logic [DIG_CW-1:0]      nd_dec;
   logic [DIG_AW-1:0]      rd_idx;
   logic [CHAR_W-1:0]      emit_char;
   logic                   emit_last;
   logic                   out_free;

   assign mag = req_data.value[VALUE_WIDTH-1] ? (~req_data.value + 1'b1) : req_data.value;
   assign bad = (base_ff < RADIX_MIN) || (base_ff > RADIX_MAX);
   assign upper = flags_ff[FLAG_UPPER];
   assign chunk_last = (cnt_ff == CHUNK_W'(DIV_CHUNKS - 1));
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign nd_dec = nd_ff - 1'b1;
   // Top of the stack as it stands after this edge.
   assign rd_idx = nd_in[DIG_AW-1:0] - 1'b1;

   // Resolve DIV_STEPS quotient bits by restoring division.
   always_comb begin
      q_next = quo_ff;
      r_next = rem_ff;
      r_wide = '0;
      for (int i = 0; i < DIV_STEPS; i++) begin
         r_wide = {r_next, q_next[VALUE_WIDTH-1]};
         q_next = {q_next[VALUE_WIDTH-2:0], 1'b0};
         if (r_wide >= {1'b0, base_ff}) begin
            r_wide = r_wide - {1'b0, base_ff};
            q_next[0] = 1'b1;
         end
         r_next = r_wide[RADIX_W-1:0];
      end
   end

   // Split the base into decimal digits for the generic prefix.
   always_comb begin
      if (base_ff >= 6'd30) begin
         tens_val = 6'd3;
      end else if (base_ff >= 6'd20) begin
         tens_val = 6'd2;
      end else if (base_ff >= 6'd10) begin
         tens_val = 6'd1;
      end else begin
         tens_val = 6'd0;
      end
      ones_val = base_ff - RADIX_W'(tens_val * RADIX_DEC);
      tens_char = CH_ZERO + {1'b0, tens_val};
      ones_char = CH_ZERO + {1'b0, ones_val};
   end

   // Build the prefix and sign characters.
   always_comb begin
      for (int i = 0; i < HEAD_MAX; i++) begin
         head[i] = CH_NUL;
      end
      head_len = '0;
      if (flags_ff[FLAG_PREFIX]) begin
         if (base_ff == RADIX_BIN) begin
            head[0] = CH_HASH;
            head[1] = digit_char(DIGIT_B, upper);
            head_len = HEAD_W'(2);
         end else if (base_ff == RADIX_OCT) begin
            head[0] = CH_HASH;
            head[1] = digit_char(DIGIT_O, upper);
            head_len = HEAD_W'(2);
         end else if (base_ff == RADIX_HEX) begin
            head[0] = CH_HASH;
            head[1] = digit_char(DIGIT_X, upper);
            head_len = HEAD_W'(2);
         end else if (base_ff != RADIX_DEC) begin
            head[0] = CH_HASH;
            head[1] = CH_LT;
            if (base_ff >= RADIX_DEC) begin
               head[2] = tens_char;
               head[3] = ones_char;
               head[4] = CH_GT;
               head_len = HEAD_W'(5);
            end else begin
               head[2] = ones_char;
               head[3] = CH_GT;
               head_len = HEAD_W'(4);
            end
         end
      end
      if (neg_ff) begin
         head[head_len] = CH_MINUS;
         head_len = head_len + 1'b1;
      end else if (flags_ff[FLAG_PLUS]) begin
         head[head_len] = CH_PLUS;
         head_len = head_len + 1'b1;
      end else if (flags_ff[FLAG_SPACE]) begin
         head[head_len] = CH_SPACE;
         head_len = head_len + 1'b1;
      end
   end

   // Select the next character: error marker, prefix and sign, then digits.
   always_comb begin
      if (bad) begin
         emit_char = CH_NUL;
         emit_last = 1'b1;
      end else if (hp_ff < head_len) begin
         emit_char = head[hp_ff];
         emit_last = 1'b0;
      end else begin
         emit_char = digit_char(dig_rd_ff, upper);
         emit_last = (nd_ff == DIG_CW'(1));
      end
   end

   // Next values of the registers.
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      base_in = base_ff;
      flags_in = flags_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      nd_in = nd_ff;
      hp_in = hp_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load) begin
         quo_in = mag;
         rem_in = '0;
         base_in = req_data.radix;
         flags_in = req_data.format_flags;
         neg_in = req_data.value[VALUE_WIDTH-1];
         cnt_in = '0;
         nd_in = '0;
         hp_in = '0;
      end
      if (cmd.div_step) begin
         quo_in = q_next;
         if (chunk_last) begin
            rem_in = '0;
            cnt_in = '0;
            nd_in = nd_ff + 1'b1;
         end else begin
            rem_in = r_next;
            cnt_in = cnt_ff + 1'b1;
         end
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_in.text_char = emit_char;
         rsp_in.last = emit_last;
         rsp_in.bad_radix = bad;
         if (!bad) begin
            if (hp_ff < head_len) begin
               hp_in = hp_ff + 1'b1;
            end else begin
               nd_in = nd_dec;
            end
         end
      end
   end

   // Hold control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         cnt_ff <= '0;
         nd_ff <= '0;
         hp_ff <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff <= cnt_in;
         nd_ff <= nd_in;
         hp_ff <= hp_in;
      end
   end

   // Hold payload registers.
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      base_ff <= base_in;
      flags_ff <= flags_in;
      neg_ff <= neg_in;
      rsp_ff <= rsp_in;
   end

   // Push a finished digit onto the stack and register the new top.
   always_ff @(posedge clock) begin
      if (cmd.div_step && chunk_last) begin
         dig_mem[nd_ff[DIG_AW-1:0]] <= r_next;
         dig_rd_ff <= r_next;
      end else begin
         dig_rd_ff <= dig_mem[rd_idx];
      end
   end

   assign status.bad = bad;
   assign status.div_done = chunk_last && (q_next == '0);
   assign status.emit_last = emit_last;
   assign status.out_free = out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

// ----- sv/integer_to_radix_text_core.sv -----
// Flow: an accept step, then each digit is divided out in the restoring divider
// (8 quotient bits a cycle), then the characters are emitted while the output is free.
// Throughput: one item at a time; a new request is taken only once the last
// character of the previous one has been loaded into the output register.
// Reset clears the controller, the datapath counters and the output valid; no clearing pass.
// Top level of the integer to radix text converter.
module integer_to_radix_text_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  i2rt_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output i2rt_pkg::rsp_type rsp_data
);
   import i2rt_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequence the conversion.
   i2rt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Compute digits and drive characters.
   i2rt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   // An error result is the only character of its conversion.
   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_radix |-> rsp_data.last)
      else $error("bad_radix result without last");

   // An error result carries the zero character.
   a_bad_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_radix |-> rsp_data.text_char == CH_NUL)
      else $error("bad_radix result with nonzero character");

   // No new item right after a transfer in.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken while a conversion is running");
`endif

endmodule
